// ===== sv/ledenc_pkg.sv =====
// ----------------------------------------------------------------------------
// LED display command encoder package
// Shared types, command constants and the seven-segment character table.
// ----------------------------------------------------------------------------
package ledenc_pkg;

    // Operation codes of a display request.
    typedef enum logic [2:0] {
        FN_DIGIT  = 3'd0,
        FN_CHAR   = 3'd1,
        FN_LED    = 3'd2,
        FN_ALLLED = 3'd3,
        FN_BRIGHT = 3'd4,
        FN_CLEAR  = 3'd5
    } t_func;

    // Kinds of byte sequence the back end produces.
    typedef enum logic [1:0] {
        OP_SINGLE = 2'd0,
        OP_ALL    = 2'd1,
        OP_BRIGHT = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    // Position of the sequencer inside one command/address/data group.
    typedef enum logic [1:0] {
        PH_CMD  = 2'd0,
        PH_ADDR = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    // Driver chip command bytes.
    localparam logic [7:0] CMD_FIXED   = 8'h44;
    localparam logic [7:0] CMD_AUTOINC = 8'h40;
    localparam logic [7:0] CMD_ADDR    = 8'hC0;
    localparam logic [7:0] CMD_BRIGHT  = 8'h88;
    localparam logic [7:0] CHAR_LO     = 8'h20;

    // Number of LEDs and of zero bytes in a display RAM clear.
    localparam int unsigned NUM_LEDS    = 8;
    localparam int unsigned CLEAR_BYTES = 16;
    localparam int unsigned IDX_W       = $clog2(CLEAR_BYTES);

    // Command queue between front and back end.
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QAW    = $clog2(QDEPTH);
    localparam int unsigned QCW    = $clog2(QDEPTH + 1);

    // One decoded command held in the queue.
    typedef struct packed {
        t_op        op;
        logic [7:0] addr;
        logic [7:0] data;
        logic [7:0] red;
    } t_cmd;

    // One output byte with its framing marks.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_start;
        logic       frame_end;
        logic       last;
    } t_rsp;

    // Seven-segment patterns for ASCII 0x20 to 0x7F.
    localparam logic [7:0] SEG_ROM [0:95] = '{
        8'h00, 8'h86, 8'h22, 8'h7E, 8'h6D, 8'hD2, 8'h46, 8'h20,
        8'h29, 8'h0B, 8'h21, 8'h70, 8'h10, 8'h40, 8'h80, 8'h52,
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h09, 8'h0D, 8'h61, 8'h48, 8'h43, 8'hD3,
        8'h5F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D,
        8'h76, 8'h30, 8'h1E, 8'h75, 8'h38, 8'h15, 8'h37, 8'h3F,
        8'h73, 8'h6B, 8'h33, 8'h6D, 8'h78, 8'h3E, 8'h3E, 8'h2A,
        8'h76, 8'h6E, 8'h5B, 8'h39, 8'h64, 8'h0F, 8'h23, 8'h08,
        8'h02, 8'h5F, 8'h7C, 8'h58, 8'h5E, 8'h7B, 8'h71, 8'h6F,
        8'h74, 8'h10, 8'h0C, 8'h75, 8'h30, 8'h14, 8'h54, 8'h5C,
        8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h1C, 8'h14,
        8'h76, 8'h6E, 8'h5B, 8'h46, 8'h30, 8'h70, 8'h01, 8'h00
    };

endpackage

// ===== sv/ledenc_if.sv =====
// ----------------------------------------------------------------------------
// LED display command encoder channels
// Request channel and output byte channel, each with valid/ready.
// ----------------------------------------------------------------------------
interface ledenc_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [2:0] position;
    logic [7:0] value;
    logic [7:0] red_mask;

    modport source (output valid, output func, output position, output value,
                    output red_mask, input ready);
    modport sink   (input valid, input func, input position, input value,
                    input red_mask, output ready);
endinterface

interface ledenc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_start;
    logic       frame_end;
    logic       last;

    modport source (output valid, output out_byte, output frame_start,
                    output frame_end, output last, input ready);
    modport sink   (input valid, input out_byte, input frame_start,
                    input frame_end, input last, output ready);
endinterface

// ===== sv/ledenc_front.sv =====
// ----------------------------------------------------------------------------
// LED display command encoder front end
// Accepts requests, decodes them into commands and pushes them to the queue.
// ----------------------------------------------------------------------------
module ledenc_front
    import ledenc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    ledenc_req_if.sink  i_req,
    input  logic        i_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic       c_known;
    logic [7:0] c_seg;
    logic [7:0] c_digit_addr;
    logic [7:0] c_led_addr;

    // A request transfers whenever the queue has room.
    assign i_req.ready = !i_full;

    // Character lookup; codes outside the table show a blank digit.
    always_comb begin
        if (!i_req.value[7] && (i_req.value >= CHAR_LO)) begin
            c_seg = SEG_ROM[7'(i_req.value - CHAR_LO)];
        end else begin
            c_seg = 8'h00;
        end
    end

    assign c_digit_addr = CMD_ADDR | {4'b0000, i_req.position, 1'b0};
    assign c_led_addr   = CMD_ADDR | {4'b0000, i_req.position, 1'b1};

    // Decode the operation into a command for the back end.
    always_comb begin
        c_known  = 1'b1;
        o_cmd.op   = OP_SINGLE;
        o_cmd.addr = c_digit_addr;
        o_cmd.data = i_req.value;
        o_cmd.red  = i_req.red_mask;
        unique case (i_req.func)
            FN_DIGIT: begin
                o_cmd.op = OP_SINGLE;
            end
            FN_CHAR: begin
                o_cmd.data = c_seg;
            end
            FN_LED: begin
                o_cmd.addr = c_led_addr;
                o_cmd.data = {6'b000000, i_req.value[1:0]};
            end
            FN_ALLLED: begin
                o_cmd.op = OP_ALL;
            end
            FN_BRIGHT: begin
                o_cmd.op = OP_BRIGHT;
            end
            FN_CLEAR: begin
                o_cmd.op = OP_CLEAR;
            end
            default: begin
                c_known = 1'b0;
            end
        endcase
    end

    // Unused operation codes are taken and produce nothing.
    assign o_push = i_req.valid && !i_full && c_known;

    // A request that produces no bytes never reaches the queue.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && (i_req.func == 3'd6 || i_req.func == 3'd7)) |-> !o_push)
        else $error("unused operation pushed to the queue");

endmodule

// ===== sv/ledenc_queue.sv =====
// ----------------------------------------------------------------------------
// LED display command encoder queue
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module ledenc_queue
    import ledenc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr;
    logic [QCW-1:0]   r_count;

    assign o_full  = (r_count == QCW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QAW'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QAW'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_push |-> !o_full)
        else $error("push into a full queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pop |-> o_valid)
        else $error("pop from an empty queue");

endmodule

// ===== sv/ledenc_back.sv =====
// ----------------------------------------------------------------------------
// LED display command encoder back end
// Steps through queued commands, one framed byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module ledenc_back
    import ledenc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  t_cmd          i_cmd,
    output logic          o_pop,
    ledenc_byte_if.source o_rsp
);

    t_phase           r_phase;
    t_phase           n_phase;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic             r_out_valid;
    t_rsp             r_out;
    t_rsp             c_rsp;
    logic             c_fire;

    // A byte is produced when a command waits and the output stage is free.
    assign c_fire = i_valid && (!r_out_valid || o_rsp.ready);
    assign o_pop  = c_fire && c_rsp.last;

    // Byte and framing for the current step.
    always_comb begin
        c_rsp = '0;
        unique case (r_phase)
            PH_CMD: begin
                c_rsp.frame_start = 1'b1;
                c_rsp.frame_end   = 1'b1;
                case (i_cmd.op)
                    OP_CLEAR:  c_rsp.out_byte = CMD_AUTOINC;
                    OP_BRIGHT: begin
                        c_rsp.out_byte = CMD_BRIGHT | {5'b00000, i_cmd.data[2:0]};
                        c_rsp.last     = 1'b1;
                    end
                    default:   c_rsp.out_byte = CMD_FIXED;
                endcase
            end
            PH_ADDR: begin
                c_rsp.frame_start = 1'b1;
                case (i_cmd.op)
                    OP_CLEAR: c_rsp.out_byte = CMD_ADDR;
                    OP_ALL:   c_rsp.out_byte = CMD_ADDR | {4'b0000, r_idx[2:0], 1'b1};
                    default:  c_rsp.out_byte = i_cmd.addr;
                endcase
            end
            PH_DATA: begin
                case (i_cmd.op)
                    OP_CLEAR: begin
                        c_rsp.frame_end = (r_idx == IDX_W'(CLEAR_BYTES - 1));
                        c_rsp.last      = (r_idx == IDX_W'(CLEAR_BYTES - 1));
                    end
                    OP_ALL: begin
                        c_rsp.out_byte  = {6'b000000, i_cmd.red[r_idx[2:0]],
                                           i_cmd.data[r_idx[2:0]]};
                        c_rsp.frame_end = 1'b1;
                        c_rsp.last      = (r_idx == IDX_W'(NUM_LEDS - 1));
                    end
                    default: begin
                        c_rsp.out_byte  = i_cmd.data;
                        c_rsp.frame_end = 1'b1;
                        c_rsp.last      = 1'b1;
                    end
                endcase
            end
            default: begin
                c_rsp = '0;
            end
        endcase
    end

    // Next phase and index of the sequencer.
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        if (c_fire) begin
            if (c_rsp.last) begin
                n_phase = PH_CMD;
                n_idx   = '0;
            end else begin
                unique case (r_phase)
                    PH_CMD:  n_phase = PH_ADDR;
                    PH_ADDR: n_phase = PH_DATA;
                    PH_DATA: begin
                        n_idx   = r_idx + 1'b1;
                        n_phase = (i_cmd.op == OP_CLEAR) ? PH_DATA : PH_CMD;
                    end
                    default: n_phase = PH_CMD;
                endcase
            end
        end
    end

    // Sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CMD;
            r_idx   <= '0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_fire) begin
            r_out <= c_rsp;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.out_byte    = r_out.out_byte;
    assign o_rsp.frame_start = r_out.frame_start;
    assign o_rsp.frame_end   = r_out.frame_end;
    assign o_rsp.last        = r_out.last;

    // Every request ends on a byte that closes its frame.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.last) |-> o_rsp.frame_end)
        else $error("final byte does not close its frame");

    // An address byte opens a frame that stays open for the data.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_fire && r_phase == PH_ADDR) |=> (r_out.frame_start && !r_out.frame_end))
        else $error("address byte framed wrongly");

    // After the final byte the sequencer is back at the start.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_phase == PH_CMD && r_idx == '0))
        else $error("sequencer not rewound after a command");

endmodule

// ===== sv/led_display_command_encoder.sv =====
// ----------------------------------------------------------------------------
// LED display command encoder
// Turns display requests into framed byte streams for a serial LED driver.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one display request per transfer (func, position, value,
//   red_mask). o_rsp carries one byte per transfer with frame_start
//   (strobe falls before the byte), frame_end (strobe rises after it) and
//   last (final byte of the request).
//   A request produces 1 (brightness), 3 (digit, character, LED),
//   18 (clear RAM) or 24 (all LEDs) bytes; unused codes produce none.
//   The back end emits one byte per cycle while a command waits and the
//   receiver keeps o_rsp.ready high; a request has 24 bytes at most.
//   A request's first byte passes the queue and the output register.
//   A two-entry command queue lets new requests transfer while earlier
//   ones are still being emitted; i_req.ready drops only when it is full.
//   When the receiver holds o_rsp.ready low, the current byte stays in the
//   output register and the sequencer waits.
//   Reset empties the queue and the output register.
// ----------------------------------------------------------------------------
module led_display_command_encoder
    import ledenc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    ledenc_req_if.sink    i_req,
    ledenc_byte_if.source o_rsp
);

    logic q_full;
    logic q_push;
    t_cmd q_in;
    logic q_valid;
    t_cmd q_out;
    logic q_pop;

    // Request decode.
    ledenc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_cmd   (q_in)
    );

    // Command queue.
    ledenc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out)
    );

    // Byte sequencer.
    ledenc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_out),
        .o_pop   (q_pop),
        .o_rsp   (o_rsp)
    );

endmodule

// ===== bench/ledenc_stream_checker.sv =====
// ----------------------------------------------------------------------------
// LED display command encoder stream checker
// Watches the request and byte channels, works out the framed byte stream
// that each accepted request must produce, and compares every byte that
// leaves the encoder with the oldest byte still expected.
// ----------------------------------------------------------------------------
module ledenc_stream_checker
    import ledenc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic       i_req_ready,
    input  logic [2:0] i_req_func,
    input  logic [2:0] i_req_position,
    input  logic [7:0] i_req_value,
    input  logic [7:0] i_req_red_mask,
    input  logic       i_rsp_valid,
    input  logic       i_rsp_ready,
    input  logic [7:0] i_rsp_out_byte,
    input  logic       i_rsp_frame_start,
    input  logic       i_rsp_frame_end,
    input  logic       i_rsp_last,
    output int         o_fail_count,
    output int         o_pending
);

    // Driver chip command bytes, kept apart from the design's own copies.
    localparam logic [7:0] FIXED_MODE    = 8'h44;
    localparam logic [7:0] AUTOINC_MODE  = 8'h40;
    localparam logic [7:0] ADDR_BASE     = 8'hC0;
    localparam logic [7:0] BRIGHT_BASE   = 8'h88;
    localparam logic [7:0] PRINTABLE_LO  = 8'h20;
    localparam logic [7:0] PRINTABLE_HI  = 8'h7F;

    // Segment patterns for ASCII 0x20 to 0x7F.
    localparam logic [7:0] CHAR_SEGMENTS [0:95] = '{
        8'h00, 8'h86, 8'h22, 8'h7E, 8'h6D, 8'hD2, 8'h46, 8'h20,
        8'h29, 8'h0B, 8'h21, 8'h70, 8'h10, 8'h40, 8'h80, 8'h52,
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h09, 8'h0D, 8'h61, 8'h48, 8'h43, 8'hD3,
        8'h5F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D,
        8'h76, 8'h30, 8'h1E, 8'h75, 8'h38, 8'h15, 8'h37, 8'h3F,
        8'h73, 8'h6B, 8'h33, 8'h6D, 8'h78, 8'h3E, 8'h3E, 8'h2A,
        8'h76, 8'h6E, 8'h5B, 8'h39, 8'h64, 8'h0F, 8'h23, 8'h08,
        8'h02, 8'h5F, 8'h7C, 8'h58, 8'h5E, 8'h7B, 8'h71, 8'h6F,
        8'h74, 8'h10, 8'h0C, 8'h75, 8'h30, 8'h14, 8'h54, 8'h5C,
        8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h1C, 8'h14,
        8'h76, 8'h6E, 8'h5B, 8'h46, 8'h30, 8'h70, 8'h01, 8'h00
    };

    t_rsp expected_bytes [$];
    int   mismatches;

    assign o_fail_count = mismatches;

    // Appends one framed byte to the expected stream.
    function automatic void add_byte(input logic [7:0] b, input logic fs, input logic fe);
        t_rsp entry;
        entry.out_byte    = b;
        entry.frame_start = fs;
        entry.frame_end   = fe;
        entry.last        = 1'b0;
        expected_bytes.push_back(entry);
    endfunction

    // Fixed-address write: mode command in its own frame, then address and data.
    function automatic void add_fixed_write(input logic [7:0] addr, input logic [7:0] data);
        add_byte(FIXED_MODE, 1'b1, 1'b1);
        add_byte(addr, 1'b1, 1'b0);
        add_byte(data, 1'b0, 1'b1);
    endfunction

    // Works out the whole byte stream of one request and queues it.
    function automatic void encode_request(input logic [2:0] func, input logic [2:0] pos,
                                           input logic [7:0] val, input logic [7:0] red);
        int   start_size;
        t_rsp tail;
        logic [7:0] seg;
        start_size = expected_bytes.size();
        case (func)
            FN_DIGIT: begin
                add_fixed_write(ADDR_BASE | {4'b0, pos, 1'b0}, val);
            end
            FN_CHAR: begin
                // Codes outside the printable range give a blank digit.
                seg = 8'h00;
                if (val >= PRINTABLE_LO && val <= PRINTABLE_HI)
                    seg = CHAR_SEGMENTS[val - PRINTABLE_LO];
                add_fixed_write(ADDR_BASE | {4'b0, pos, 1'b0}, seg);
            end
            FN_LED: begin
                add_fixed_write(ADDR_BASE + 8'd1 + {4'b0, pos, 1'b0}, {6'b0, val[1:0]});
            end
            FN_ALLLED: begin
                // Green bit into data bit 0, red bit into data bit 1.
                for (int i = 0; i < 8; i++)
                    add_fixed_write(ADDR_BASE + 8'(2 * i + 1), {6'b0, red[i], val[i]});
            end
            FN_BRIGHT: begin
                add_byte(BRIGHT_BASE | {5'b0, val[2:0]}, 1'b1, 1'b1);
            end
            FN_CLEAR: begin
                add_byte(AUTOINC_MODE, 1'b1, 1'b1);
                add_byte(ADDR_BASE, 1'b1, 1'b0);
                for (int i = 0; i < 16; i++)
                    add_byte(8'h00, 1'b0, i == 15);
            end
            default: begin
                // Spare operation codes produce no bytes.
            end
        endcase
        if (expected_bytes.size() > start_size) begin
            tail = expected_bytes.pop_back();
            tail.last = 1'b1;
            expected_bytes.push_back(tail);
        end
    endfunction

    // Counts a mismatch; only the first few are printed.
    function automatic void report_mismatch(input string what, input t_rsp want,
                                            input t_rsp got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected byte=%02h fs=%0b fe=%0b last=%0b,",
                     $time, what, want.out_byte, want.frame_start, want.frame_end,
                     want.last, " got byte=%02h fs=%0b fe=%0b last=%0b",
                     got.out_byte, got.frame_start, got.frame_end, got.last);
    endfunction

    initial begin
        mismatches = 0;
        o_pending  = 0;
    end

    // Sample both channels at each edge, predict on requests, compare on bytes.
    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        if (!i_rst_n) begin
            expected_bytes.delete();
        end else begin
            if (i_req_valid && i_req_ready)
                encode_request(i_req_func, i_req_position, i_req_value, i_req_red_mask);
            if (i_rsp_valid && i_rsp_ready) begin
                got.out_byte    = i_rsp_out_byte;
                got.frame_start = i_rsp_frame_start;
                got.frame_end   = i_rsp_frame_end;
                got.last        = i_rsp_last;
                if (expected_bytes.size() == 0) begin
                    want = '0;
                    report_mismatch("unexpected byte", want, got);
                end else begin
                    want = expected_bytes.pop_front();
                    if (want.out_byte !== got.out_byte || want.frame_start !== got.frame_start
                        || want.frame_end !== got.frame_end || want.last !== got.last)
                        report_mismatch("byte mismatch", want, got);
                end
            end
        end
        o_pending <= expected_bytes.size();
    end

endmodule

// ===== bench/tb_led_display_command_encoder.sv =====
// ----------------------------------------------------------------------------
// LED display command encoder testbench
// Sends directed and random display requests with random gaps on both
// channels, including a long output stall and a full drain, while a
// separate checker predicts and compares every byte of the output stream.
// ----------------------------------------------------------------------------
module tb_led_display_command_encoder;
    import ledenc_pkg::*;

    // Operation codes the encoder does not use.
    localparam logic [2:0] FN_SPARE_A = 3'd6;
    localparam logic [2:0] FN_SPARE_B = 3'd7;

    localparam int RANDOM_REQUESTS = 280;
    localparam int LONG_HOLD       = 200;
    localparam int TAIL_CYCLES     = 40;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending_bytes;
    bit   steady;
    bit   hold_output;

    ledenc_req_if  req_ch ();
    ledenc_byte_if rsp_ch ();

    led_display_command_encoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    ledenc_stream_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req_valid       (req_ch.valid),
        .i_req_ready       (req_ch.ready),
        .i_req_func        (req_ch.func),
        .i_req_position    (req_ch.position),
        .i_req_value       (req_ch.value),
        .i_req_red_mask    (req_ch.red_mask),
        .i_rsp_valid       (rsp_ch.valid),
        .i_rsp_ready       (rsp_ch.ready),
        .i_rsp_out_byte    (rsp_ch.out_byte),
        .i_rsp_frame_start (rsp_ch.frame_start),
        .i_rsp_frame_end   (rsp_ch.frame_end),
        .i_rsp_last        (rsp_ch.last),
        .o_fail_count      (fail_count),
        .o_pending         (pending_bytes)
    );

    // Clock with a period of two time units.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard limit on the run length.
    initial begin
        #3000000;
        $display("Verification failed");
        $finish;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Byte receiver: random stalls, plus one long hold-off on request.
    initial begin
        int gap;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_output) begin
                hold_output = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            gap = idle_cycles();
            if (gap > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    // Offers one request after a random gap and waits for its transfer.
    task automatic send_request(input logic [2:0] func, input logic [2:0] pos,
                                input logic [7:0] val, input logic [7:0] red);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.func     <= func;
        req_ch.position <= pos;
        req_ch.value    <= val;
        req_ch.red_mask <= red;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    // Stops offering and waits until every expected byte has come out.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_bytes != 0) @(posedge i_clk);
    endtask

    // Random request; character codes lean toward the printable range.
    task automatic send_random_request();
        int         r;
        logic [2:0] func;
        logic [7:0] val;
        r = $urandom_range(0, 19);
        if (r < 18)
            func = 3'(r % 6);
        else
            func = (r == 18) ? FN_SPARE_A : FN_SPARE_B;
        val = 8'($urandom);
        if (func == FN_CHAR && $urandom_range(0, 1) == 1)
            val = 8'($urandom_range(8'h20, 8'h7F));
        send_request(func, 3'($urandom), val, 8'($urandom));
    endtask

    // Stimulus and verdict.
    initial begin
        steady          = 1'b0;
        hold_output     = 1'b0;
        i_rst_n         <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.func     <= FN_DIGIT;
        req_ch.position <= 3'd0;
        req_ch.value    <= 8'h00;
        req_ch.red_mask <= 8'h00;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: field extremes, every operation and the blank characters.
        send_request(FN_DIGIT, 3'd0, 8'h00, 8'hFF);
        send_request(FN_DIGIT, 3'd7, 8'hFF, 8'h00);
        send_request(FN_CHAR, 3'd0, 8'h20, 8'h00);
        send_request(FN_CHAR, 3'd7, 8'h7F, 8'hFF);
        send_request(FN_CHAR, 3'd1, 8'h1F, 8'h00);
        send_request(FN_CHAR, 3'd2, 8'h80, 8'h00);
        send_request(FN_CHAR, 3'd3, 8'h00, 8'h00);
        send_request(FN_CHAR, 3'd4, 8'hFF, 8'h00);
        send_request(FN_CHAR, 3'd5, 8'h41, 8'h00);
        send_request(FN_CHAR, 3'd6, 8'h7E, 8'h00);
        send_request(FN_LED, 3'd0, 8'h00, 8'h00);
        send_request(FN_LED, 3'd7, 8'hFF, 8'hFF);
        send_request(FN_LED, 3'd4, 8'h02, 8'h00);
        send_request(FN_ALLLED, 3'd0, 8'h00, 8'hFF);
        send_request(FN_ALLLED, 3'd7, 8'hFF, 8'h00);
        send_request(FN_ALLLED, 3'd3, 8'hA5, 8'h5A);
        send_request(FN_BRIGHT, 3'd0, 8'h00, 8'h00);
        send_request(FN_BRIGHT, 3'd7, 8'h07, 8'hFF);
        send_request(FN_BRIGHT, 3'd2, 8'hF8, 8'h00);
        send_request(FN_CLEAR, 3'd0, 8'h00, 8'h00);
        send_request(FN_CLEAR, 3'd7, 8'hFF, 8'hFF);
        send_request(FN_SPARE_A, 3'd5, 8'h33, 8'hCC);
        send_request(FN_SPARE_B, 3'd2, 8'hCC, 8'h33);
        send_request(FN_DIGIT, 3'd5, 8'h3C, 8'h00);

        // Let the encoder run dry before the back-pressure test.
        wait_drained();

        // Long output hold-off while requests keep coming, so the queue fills.
        steady      = 1'b1;
        hold_output = 1'b1;
        for (int k = 0; k < 8; k++)
            send_request((k % 2 == 0) ? FN_ALLLED : FN_CLEAR, 3'($urandom),
                         8'($urandom), 8'($urandom));
        steady = 1'b0;

        // Random part, with stretches where neither side idles.
        for (int k = 0; k < RANDOM_REQUESTS; k++) begin
            steady = ((k / 40) % 3 == 1);
            send_random_request();
        end
        steady = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_bytes == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
